// ===== hdl/swdr_pkg.sv =====
// ----------------------------------------------------------------------------
// swdr_pkg
// Shared types and constants for the stack with duplicate removal.
// ----------------------------------------------------------------------------
package swdr_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_DEDUP = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_DATA,
    S_CAND_RD,
    S_CAND_LD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_WRITE,
    S_NEXT
  } state_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_I,
    RD_J
  } rd_sel_t;

  typedef struct packed {
    logic       push_wr;
    logic       pop_rd;
    logic       pop_ld;
    logic       res_ld;
    logic [1:0] res_status;
    rd_sel_t    rd_sel;
    logic       dd_init;
    logic       cand_ld;
    logic       scan_adv;
    logic       dd_wr;
    logic       dd_adv;
    logic       dd_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic i_last;
    logic j_last;
    logic match;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/swdr_req_if.sv =====
// ----------------------------------------------------------------------------
// swdr_req_if
// Request channel: one word carries an action and a value to push.
// ----------------------------------------------------------------------------
interface swdr_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic signed [swdr_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, action, push_value, input ready);
  modport sink   (input valid, action, push_value, output ready);
endinterface

// ===== hdl/swdr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// swdr_rsp_if
// Response channel: one word per request with value, status and count.
// ----------------------------------------------------------------------------
interface swdr_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swdr_pkg::DATA_W-1:0]   popped_value;
  logic [1:0]                           status;
  logic [6:0]                           entry_count;

  modport source (output valid, popped_value, status, entry_count, input ready);
  modport sink   (input valid, popped_value, status, entry_count, output ready);
endinterface

// ===== hdl/stack_with_duplicate_removal_core.sv =====
// ----------------------------------------------------------------------------
// stack_with_duplicate_removal_core
// Bounded LIFO stack of signed 32-bit values with in-place duplicate removal.
// ----------------------------------------------------------------------------
// Requests arrive on req (action, push_value) and each gives exactly one
// response word on rsp (popped_value, status, entry_count); a word moves
// when valid and ready are both high.
// A push's response is registered in the cycle after acceptance, so
// back-to-back pushes run at one word per cycle while rsp.ready stays high.
// A pop reads the top entry through the single registered read port of the
// stack memory and loads its response from S_POP_DATA. A dedup walks the
// memory with that same read port: for each entry it compares against the
// entries above it and compacts survivors downwards; req.ready stays low
// for the whole walk. Errors (pop on empty, push on full) and dedup on an
// empty stack load their response on acceptance and leave the stack intact.
// Reset empties the stack and drops any waiting response; memory contents
// are not cleared. While rsp is stalled the response register holds, and a
// new request is taken only once that word is leaving.
// ----------------------------------------------------------------------------
module stack_with_duplicate_removal_core (
  input  logic       clk,
  input  logic       rst,
  swdr_req_if.sink   req,
  swdr_rsp_if.source rsp
);

  swdr_pkg::dp_cmd_t  cmd;
  swdr_pkg::dp_stat_t stat;

  swdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .action   (req.action),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swdr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .push_value (req.push_value),
    .rsp        (rsp)
  );

endmodule

// ===== hdl/swdr_datapath.sv =====
// ----------------------------------------------------------------------------
// swdr_datapath
// Stack memory, fill count, dedup walk counters and the response register.
// ----------------------------------------------------------------------------
module swdr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  swdr_pkg::dp_cmd_t                   cmd,
  output swdr_pkg::dp_stat_t                  stat,
  input  logic signed [swdr_pkg::DATA_W-1:0]  push_value,
  swdr_rsp_if.source                          rsp
);

  logic [swdr_pkg::DATA_W-1:0] mem [swdr_pkg::DEPTH];
  logic [swdr_pkg::DATA_W-1:0] rdata;
  logic [swdr_pkg::ADDR_W-1:0] raddr;
  logic [swdr_pkg::ADDR_W-1:0] waddr;
  logic [swdr_pkg::DATA_W-1:0] wdata;
  logic                        we;

  logic [swdr_pkg::CNT_W-1:0]  count;
  logic [swdr_pkg::CNT_W-1:0]  count_next;
  logic [swdr_pkg::CNT_W-1:0]  count_m1;
  logic [swdr_pkg::CNT_W-1:0]  i;
  logic [swdr_pkg::CNT_W-1:0]  j;
  logic [swdr_pkg::CNT_W-1:0]  w;
  logic [swdr_pkg::DATA_W-1:0] cand;

  logic                        out_valid;
  logic [swdr_pkg::DATA_W-1:0] out_popped;
  logic [1:0]                  out_status;
  logic [swdr_pkg::CNT_W-1:0]  out_count;

  assign count_m1 = count - swdr_pkg::CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      swdr_pkg::RD_TOP: raddr = count_m1[swdr_pkg::ADDR_W-1:0];
      swdr_pkg::RD_I:   raddr = i[swdr_pkg::ADDR_W-1:0];
      swdr_pkg::RD_J:   raddr = j[swdr_pkg::ADDR_W-1:0];
      default:          raddr = count_m1[swdr_pkg::ADDR_W-1:0];
    endcase
  end

  // A push writes above the top; the dedup walk compacts survivors downwards.
  assign we    = cmd.push_wr | cmd.dd_wr;
  assign waddr = cmd.push_wr ? count[swdr_pkg::ADDR_W-1:0] : w[swdr_pkg::ADDR_W-1:0];
  assign wdata = cmd.push_wr ? push_value : cand;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    if (cmd.push_wr) begin
      count_next = count + swdr_pkg::CNT_W'(1);
    end else if (cmd.pop_rd) begin
      count_next = count_m1;
    end else if (cmd.dd_fin) begin
      count_next = w;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Walk counters and candidate value carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.dd_init) begin
      i <= '0;
      w <= '0;
    end else begin
      if (cmd.dd_adv) begin
        i <= i + swdr_pkg::CNT_W'(1);
      end
      if (cmd.dd_wr) begin
        w <= w + swdr_pkg::CNT_W'(1);
      end
    end
    if (cmd.cand_ld) begin
      cand <= rdata;
      j    <= i + swdr_pkg::CNT_W'(1);
    end else if (cmd.scan_adv) begin
      j <= j + swdr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_ld || cmd.pop_ld) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_ld) begin
      out_popped <= rdata;
      out_status <= swdr_pkg::ST_OK;
      out_count  <= count_next;
    end else if (cmd.res_ld) begin
      out_popped <= '0;
      out_status <= cmd.res_status;
      out_count  <= count_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.popped_value = out_popped;
  assign rsp.status       = out_status;
  assign rsp.entry_count  = 7'(out_count);

  assign stat.count_zero = (count == '0);
  assign stat.count_full = (count == swdr_pkg::CNT_W'(swdr_pkg::DEPTH));
  assign stat.i_last     = ((i + swdr_pkg::CNT_W'(1)) == count);
  assign stat.j_last     = ((j + swdr_pkg::CNT_W'(1)) == count);
  assign stat.match      = (rdata == cand);
  assign stat.out_free   = !out_valid || rsp.ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= swdr_pkg::CNT_W'(swdr_pkg::DEPTH))
    else $error("stack count exceeds its depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.push_wr |=> count == swdr_pkg::CNT_W'($past(count) + swdr_pkg::CNT_W'(1)))
    else $error("push did not raise the count by one");

  a_dedup_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.dd_fin |-> w <= count)
    else $error("dedup would leave more entries than it started with");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_ld || cmd.pop_ld) |-> stat.out_free)
    else $error("result loaded over a word still waiting");

endmodule

// ===== hdl/swdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// swdr_ctrl
// Sequencer for push, pop and the duplicate removal walk.
// ----------------------------------------------------------------------------
module swdr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          action,
  output logic                in_ready,
  input  swdr_pkg::dp_stat_t  stat,
  output swdr_pkg::dp_cmd_t   cmd
);

  swdr_pkg::state_t state;
  swdr_pkg::state_t state_next;
  logic             accept;

  assign in_ready = (state == swdr_pkg::S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swdr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      swdr_pkg::S_IDLE: begin
        if (accept) begin
          if (action == swdr_pkg::ACT_POP && !stat.count_zero) begin
            state_next = swdr_pkg::S_POP_DATA;
          end else if (action == swdr_pkg::ACT_DEDUP && !stat.count_zero) begin
            state_next = swdr_pkg::S_CAND_RD;
          end
        end
      end
      swdr_pkg::S_POP_DATA: state_next = swdr_pkg::S_IDLE;
      swdr_pkg::S_CAND_RD:  state_next = swdr_pkg::S_CAND_LD;
      swdr_pkg::S_CAND_LD: begin
        state_next = stat.i_last ? swdr_pkg::S_WRITE : swdr_pkg::S_SCAN_RD;
      end
      swdr_pkg::S_SCAN_RD:  state_next = swdr_pkg::S_SCAN_CMP;
      swdr_pkg::S_SCAN_CMP: begin
        if (stat.match) begin
          state_next = swdr_pkg::S_NEXT;
        end else if (stat.j_last) begin
          state_next = swdr_pkg::S_WRITE;
        end else begin
          state_next = swdr_pkg::S_SCAN_RD;
        end
      end
      swdr_pkg::S_WRITE: state_next = swdr_pkg::S_NEXT;
      swdr_pkg::S_NEXT: begin
        state_next = stat.i_last ? swdr_pkg::S_IDLE : swdr_pkg::S_CAND_RD;
      end
      default: state_next = swdr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = swdr_pkg::RD_TOP;
    cmd.res_status = swdr_pkg::ST_OK;
    unique case (state)
      swdr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (action)
            swdr_pkg::ACT_PUSH: begin
              cmd.res_ld = 1'b1;
              if (stat.count_full) begin
                cmd.res_status = swdr_pkg::ST_FULL;
              end else begin
                cmd.push_wr = 1'b1;
              end
            end
            swdr_pkg::ACT_POP: begin
              if (stat.count_zero) begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = swdr_pkg::ST_EMPTY;
              end else begin
                cmd.pop_rd = 1'b1;
              end
            end
            swdr_pkg::ACT_DEDUP: begin
              if (stat.count_zero) begin
                cmd.res_ld = 1'b1;
              end else begin
                cmd.dd_init = 1'b1;
              end
            end
            default: cmd.res_ld = 1'b1;
          endcase
        end
      end
      swdr_pkg::S_POP_DATA: cmd.pop_ld = 1'b1;
      swdr_pkg::S_CAND_RD:  cmd.rd_sel = swdr_pkg::RD_I;
      swdr_pkg::S_CAND_LD:  cmd.cand_ld = 1'b1;
      swdr_pkg::S_SCAN_RD:  cmd.rd_sel = swdr_pkg::RD_J;
      swdr_pkg::S_SCAN_CMP: begin
        if (!stat.match) begin
          cmd.scan_adv = 1'b1;
        end
      end
      swdr_pkg::S_WRITE: cmd.dd_wr = 1'b1;
      swdr_pkg::S_NEXT: begin
        // The walk ends once the top entry has been handled.
        if (stat.i_last) begin
          cmd.dd_fin = 1'b1;
          cmd.res_ld = 1'b1;
        end else begin
          cmd.dd_adv = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_pop_follows_idle: assert property (@(posedge clk) disable iff (rst)
    state == swdr_pkg::S_POP_DATA |-> $past(state) == swdr_pkg::S_IDLE && $past(cmd.pop_rd))
    else $error("pop data cycle without a pop read");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.dd_init |=> !in_ready)
    else $error("request channel open during the dedup walk");

endmodule
